[sv/u2u_pkg.sv]
package u2u_pkg;

  // Most UTF-16 units that one input byte can release.
  localparam int unsigned MaxUnits = 4;

  // Default number of bundles held between the front and the back.
  localparam int unsigned QueueDepthDefault = 4;

  localparam logic [15:0] ReplacementUnit = 16'hFFFD;
  localparam logic [15:0] HighSurrogate   = 16'hD800;
  localparam logic [15:0] LowSurrogate    = 16'hDC00;
  localparam logic [20:0] PlaneOffset     = 21'h10000;

  // All units released by one input byte, handed from the front to the back.
  typedef struct packed {
    logic [MaxUnits-1:0][15:0] units;
    logic [1:0]                last_idx;
    logic                      eos;
  } bundle_t;

endpackage

[sv/utf8_to_utf16_transcoder_unit.sv]
// UTF-8 to UTF-16 transcoder.
// The input side is a queue: drive a byte of a zero-terminated UTF-8 string on
// text_byte_i and raise push; the transfer happens on a clock edge where full
// is low. The output side is a queue too: while empty is low, the oldest UTF-16
// unit sits on code_unit_o, and end_of_string_o marks the zero terminator that
// closes each string. Raising pop while empty is low transfers that unit.
// The front decodes one byte per cycle and, whenever a byte completes a
// character, ends a string or is invalid, writes all of its units (one to
// four) as a single bundle into a small queue. The back drains the head
// bundle one unit per cycle into the output register, so the first unit of a
// byte goes through the queue and then the output register. Input throughput is one byte
// per cycle as long as the queue has room; the drain rate of one unit per
// cycle is what limits it, so surrogate pairs and truncated sequences cost
// extra cycles that the QueueDepth bundles of buffering absorb.
// When the receiver stalls, the output unit holds, the queue fills, and full
// rises to stop the sender. Reset empties the queue and the output register
// and drops any partially received sequence; no clearing pass is needed.
module utf8_to_utf16_transcoder_unit #(
  parameter int unsigned QueueDepth = u2u_pkg::QueueDepthDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  text_byte_i,
  input  logic        pop,
  output logic        empty,
  output logic [15:0] code_unit_o,
  output logic        end_of_string_o
);
  import u2u_pkg::*;

  logic    take;
  logic    q_push, q_empty, q_full, q_pop;
  bundle_t q_wdata, q_rdata;

  // A byte is taken whenever the queue can hold whatever it may produce.
  assign full = q_full;
  assign take = push && !q_full;

  u2u_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .take_i         (take),
    .text_byte_i    (text_byte_i),
    .bundle_valid_o (q_push),
    .bundle_o       (q_wdata)
  );

  u2u_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .data_i  (q_wdata),
    .pop_i   (q_pop),
    .data_o  (q_rdata),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  u2u_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_valid_i    (!q_empty),
    .head_i          (q_rdata),
    .head_done_o     (q_pop),
    .pop_i           (pop),
    .empty_o         (empty),
    .code_unit_o     (code_unit_o),
    .end_of_string_o (end_of_string_o)
  );

  // A terminator byte always produces a bundle that closes the string.
  a_nul_ends_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && text_byte_i == 8'h00) |-> (q_push && q_wdata.eos))
    else $error("terminator byte did not produce an end-of-string bundle");

  // Any other byte never closes a string.
  a_no_false_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && text_byte_i != 8'h00) |-> !(q_push && q_wdata.eos))
    else $error("non-terminator byte produced an end-of-string bundle");

  // The unit flagged as the end of a string is always the zero terminator.
  a_end_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && end_of_string_o) |-> (code_unit_o == 16'h0000))
    else $error("end-of-string unit is not zero");

endmodule

[sv/u2u_front.sv]
module u2u_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             take_i,
  input  logic [7:0]       text_byte_i,
  output logic             bundle_valid_o,
  output u2u_pkg::bundle_t bundle_o
);
  import u2u_pkg::*;

  typedef enum logic [2:0] {
    LEAD_ASCII,
    LEAD_TWO,
    LEAD_THREE,
    LEAD_FOUR,
    LEAD_BAD
  } lead_e;

  function automatic lead_e classify(logic [7:0] b);
    lead_e c;
    if (!b[7]) c = LEAD_ASCII;
    else if (b[7:5] == 3'b110) c = LEAD_TWO;
    else if (b[7:4] == 4'b1110) c = LEAD_THREE;
    else if (b[7:3] == 5'b11110) c = LEAD_FOUR;
    else c = LEAD_BAD;
    return c;
  endfunction

  // A byte decoded on its own during a flush: plain ASCII or a replacement.
  function automatic logic [15:0] single_unit(logic [7:0] b, lead_e c);
    logic [15:0] u;
    u = (c == LEAD_ASCII) ? {8'h00, b} : ReplacementUnit;
    return u;
  endfunction

  logic [1:0] cnt_q, cnt_d;
  logic [7:0] pb_q [3];
  logic       wr_en;
  logic [1:0] wr_idx;
  lead_e      lead0, lead1, lead2, lead_b;
  logic [1:0] need;
  logic [20:0] cp, cp_off;
  bundle_t    bundle_d;
  logic       valid_d;

  always_comb begin
    lead0  = classify(pb_q[0]);
    lead1  = classify(pb_q[1]);
    lead2  = classify(pb_q[2]);
    lead_b = classify(text_byte_i);

    unique case (lead0)
      LEAD_TWO:   need = 2'd1;
      LEAD_THREE: need = 2'd2;
      LEAD_FOUR:  need = 2'd3;
      default:    need = 2'd0;
    endcase

    unique case (cnt_q)
      2'd1:    cp = {10'b0, pb_q[0][4:0], text_byte_i[5:0]};
      2'd2:    cp = {5'b0, pb_q[0][3:0], pb_q[1][5:0], text_byte_i[5:0]};
      default: cp = {pb_q[0][2:0], pb_q[1][5:0], pb_q[2][5:0], text_byte_i[5:0]};
    endcase
    cp_off = cp - PlaneOffset;

    bundle_d = '0;
    valid_d  = 1'b0;
    cnt_d    = cnt_q;
    wr_en    = 1'b0;
    wr_idx   = cnt_q;

    if (cnt_q == 2'd0) begin
      if (text_byte_i == 8'h00) begin
        bundle_d.eos = 1'b1;
        valid_d      = 1'b1;
      end else begin
        unique case (lead_b) inside
          LEAD_ASCII: begin
            bundle_d.units[0] = {8'h00, text_byte_i};
            valid_d           = 1'b1;
          end
          LEAD_TWO, LEAD_THREE, LEAD_FOUR: begin
            wr_en = 1'b1;
            cnt_d = 2'd1;
          end
          default: begin
            bundle_d.units[0] = ReplacementUnit;
            valid_d           = 1'b1;
          end
        endcase
      end
    end else if (text_byte_i == 8'h00) begin
      // Cut short: the open lead is replaced, the bytes behind it are
      // decoded again as leads of their own, then the terminator follows.
      bundle_d.units[0] = ReplacementUnit;
      bundle_d.eos      = 1'b1;
      valid_d           = 1'b1;
      cnt_d             = 2'd0;
      unique case (cnt_q)
        2'd1: begin
          bundle_d.last_idx = 2'd1;
        end
        2'd2: begin
          bundle_d.units[1] = single_unit(pb_q[1], lead1);
          bundle_d.last_idx = 2'd2;
        end
        default: begin
          if (lead1 == LEAD_TWO) begin
            bundle_d.units[1] = {5'b0, pb_q[1][4:0], pb_q[2][5:0]};
            bundle_d.last_idx = 2'd2;
          end else begin
            bundle_d.units[1] = single_unit(pb_q[1], lead1);
            bundle_d.units[2] = single_unit(pb_q[2], lead2);
            bundle_d.last_idx = 2'd3;
          end
        end
      endcase
    end else if (cnt_q >= need) begin
      valid_d = 1'b1;
      cnt_d   = 2'd0;
      if (|cp[20:16]) begin
        bundle_d.units[0] = HighSurrogate | {5'b0, cp_off[20:10]};
        bundle_d.units[1] = LowSurrogate | {6'b0, cp_off[9:0]};
        bundle_d.last_idx = 2'd1;
      end else begin
        bundle_d.units[0] = cp[15:0];
      end
    end else begin
      wr_en = 1'b1;
      cnt_d = cnt_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (take_i) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && wr_en) begin
      pb_q[wr_idx] <= text_byte_i;
    end
  end

  assign bundle_valid_o = take_i && valid_d;
  assign bundle_o       = bundle_d;

endmodule

[sv/u2u_queue.sv]
module u2u_queue #(
  parameter int unsigned Depth = u2u_pkg::QueueDepthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  u2u_pkg::bundle_t data_i,
  input  logic             pop_i,
  output u2u_pkg::bundle_t data_o,
  output logic             empty_o,
  output logic             full_o
);
  import u2u_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  bundle_t         mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == FullCnt);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

[sv/u2u_back.sv]
module u2u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  u2u_pkg::bundle_t head_i,
  output logic             head_done_o,
  input  logic             pop_i,
  output logic             empty_o,
  output logic [15:0]      code_unit_o,
  output logic             end_of_string_o
);
  import u2u_pkg::*;

  logic [1:0]  idx_q;
  logic        out_valid_q;
  logic [15:0] code_q;
  logic        eos_q;
  logic        load, at_last;

  assign load        = head_valid_i && (!out_valid_q || pop_i);
  assign at_last     = (idx_q == head_i.last_idx);
  assign head_done_o = load && at_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else if (load) begin
      idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
      out_valid_q <= 1'b1;
    end else if (pop_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      code_q <= head_i.units[idx_q];
      eos_q  <= head_i.eos && at_last;
    end
  end

  assign empty_o         = !out_valid_q;
  assign code_unit_o     = code_q;
  assign end_of_string_o = eos_q;

endmodule

[tb/sv/utf8_to_utf16_transcoder_checker.sv]
module utf8_to_utf16_transcoder_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [7:0]  text_byte_i,
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [15:0] code_unit_i,
  input  logic        end_of_string_i,
  output int unsigned mismatch_count_o,
  output int unsigned outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  import u2u_pkg::*;

  // The value of each valid lead class is the number of bytes that follow the lead; LeadBad is -1.
  typedef enum int {
    LeadBad    = -1,
    LeadSingle = 0,
    LeadDouble = 1,
    LeadTriple = 2,
    LeadQuad   = 3
  } lead_e;

  typedef struct packed {
    logic [15:0] unit;
    logic        eos;
  } utf16_unit_t;

  utf16_unit_t expected_units_q[$];
  logic [7:0]  held_bytes [3];
  int          held_count;
  int          released;
  int unsigned mismatches;

  function automatic lead_e classify_lead(input logic [7:0] b);
    if (b < 8'h80) return LeadSingle;
    if ((b & 8'hE0) == 8'hC0) return LeadDouble;
    if ((b & 8'hF0) == 8'hE0) return LeadTriple;
    if ((b & 8'hF8) == 8'hF0) return LeadQuad;
    return LeadBad;
  endfunction

  // seq[0] is the lead; follow is the number of bytes after it.
  function automatic logic [20:0] code_point(input logic [3:0][7:0] seq, input int follow);
    case (follow)
      1: return {10'b0, seq[0][4:0], seq[1][5:0]};
      2: return {5'b0, seq[0][3:0], seq[1][5:0], seq[2][5:0]};
      default: return {seq[0][2:0], seq[1][5:0], seq[2][5:0], seq[3][5:0]};
    endcase
  endfunction

  // One byte never releases more than MaxUnits units; extra ones are dropped.
  task automatic emit_unit(input logic [15:0] unit, input logic eos);
    utf16_unit_t entry;
    entry.unit = unit;
    entry.eos  = eos;
    if (released < MaxUnits) expected_units_q.insert(expected_units_q.size(), entry);
    released++;
  endtask

  task automatic emit_point(input logic [20:0] cp);
    logic [20:0] offset;
    if (cp < PlaneOffset) begin
      emit_unit(cp[15:0], 1'b0);
    end else begin
      offset = cp - PlaneOffset;
      emit_unit(HighSurrogate | {5'b0, offset[20:10]}, 1'b0);
      emit_unit(LowSurrogate | {6'b0, offset[9:0]}, 1'b0);
    end
  endtask

  task automatic transcode_byte(input logic [7:0] b);
    lead_e            kind;
    int               follow;
    int               pos;
    logic [3:0][7:0]  seq;
    released = 0;
    if (held_count == 0) begin
      kind = classify_lead(b);
      if (b == 8'h00) begin
        emit_unit(16'h0000, 1'b1);
      end else if (kind == LeadSingle) begin
        emit_unit({8'h00, b}, 1'b0);
      end else if (kind == LeadBad) begin
        emit_unit(ReplacementUnit, 1'b0);
      end else begin
        held_bytes[0] = b;
        held_count = 1;
      end
    end else if (b == 8'h00) begin
      // The string ended inside a sequence: the held bytes are decoded again as leads.
      pos = 0;
      while (pos < held_count) begin
        kind = classify_lead(held_bytes[pos]);
        follow = int'(kind);
        if (kind == LeadSingle) begin
          emit_unit({8'h00, held_bytes[pos]}, 1'b0);
          pos++;
        end else if (kind != LeadBad && pos + follow < held_count) begin
          seq = '0;
          for (int j = 0; j <= follow; j++) seq[j] = held_bytes[pos + j];
          emit_point(code_point(seq, follow));
          pos += follow + 1;
        end else begin
          emit_unit(ReplacementUnit, 1'b0);
          pos++;
        end
      end
      held_count = 0;
      emit_unit(16'h0000, 1'b1);
    end else begin
      follow = int'(classify_lead(held_bytes[0]));
      if (held_count >= follow) begin
        seq = '0;
        for (int j = 0; j < held_count; j++) seq[j] = held_bytes[j];
        seq[held_count] = b;
        emit_point(code_point(seq, held_count));
        held_count = 0;
      end else begin
        held_bytes[held_count] = b;
        held_count++;
      end
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("%0t ns: mismatch: %s", $time, what);
    mismatches++;
  endtask

  always @(posedge clk_i) begin : watch_channels
    utf16_unit_t oldest;
    if (!rst_ni) begin
      expected_units_q.delete();
      held_bytes = '{default: 8'h00};
      held_count = 0;
      mismatches = 0;
    end else begin
      if (push_i && !full_i) transcode_byte(text_byte_i);
      if (pop_i && !empty_i) begin
        if (expected_units_q.size() == 0) begin
          report_mismatch($sformatf("unit %h eos %b with nothing expected",
                                    code_unit_i, end_of_string_i));
        end else begin
          oldest = expected_units_q.pop_front();
          if (code_unit_i !== oldest.unit)
            report_mismatch($sformatf("code unit %h, expected %h", code_unit_i, oldest.unit));
          if (end_of_string_i !== oldest.eos)
            report_mismatch($sformatf("end of string %b, expected %b on unit %h",
                                      end_of_string_i, oldest.eos, oldest.unit));
        end
      end
    end
    mismatch_count_o <= mismatches;
    outstanding_o    <= expected_units_q.size();
  end

endmodule

[tb/sv/utf8_to_utf16_transcoder_unit_test.sv]
module utf8_to_utf16_transcoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  // Cycles without any transfer before the run is declared hung. The longest
  // legal quiet stretch is the receiver hold-off below, so this leaves a wide margin.
  localparam int unsigned QuietLimit = 2000;
  // Length of the receiver hold-off that fills the block and raises full.
  localparam int unsigned LongHold = 200;
  // Cycles to watch the output after the last expected unit has arrived.
  localparam int unsigned DrainCycles = 16;
  // Least number of random bytes per phase, after the directed part.
  localparam int unsigned PhaseBytes = 74;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  text_byte = 8'h00;
  logic        pop = 1'b0;
  logic        empty;
  logic [15:0] code_unit;
  logic        end_of_string;

  int unsigned mismatch_count;
  int unsigned outstanding;

  // Idle percentages of the two sides; the stimulus changes them per phase.
  int unsigned send_idle_pct = 0;
  int unsigned take_idle_pct = 0;
  int unsigned bytes_sent = 0;
  bit          hold_off_req = 1'b0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  utf8_to_utf16_transcoder_unit u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .push           (push),
    .full           (full),
    .text_byte_i    (text_byte),
    .pop            (pop),
    .empty          (empty),
    .code_unit_o    (code_unit),
    .end_of_string_o(end_of_string)
  );

  utf8_to_utf16_transcoder_checker u_checker (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .push_i          (push),
    .full_i          (full),
    .text_byte_i     (text_byte),
    .pop_i           (pop),
    .empty_i         (empty),
    .code_unit_i     (code_unit),
    .end_of_string_i (end_of_string),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  // Offers one byte and returns right after the edge where its transfer happens.
  // Random idle cycles come first, with junk on the data lines. A byte that
  // follows at once keeps push high, so push is assigned only once per step.
  task automatic send_byte(input logic [7:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      text_byte <= 8'($urandom);
      @(posedge clk);
    end
    push <= 1'b1;
    text_byte <= value;
    do @(posedge clk); while (full);
    bytes_sent++;
  endtask

  // A lead byte that opens a sequence with the given number of following bytes.
  function automatic logic [7:0] lead_byte(input int follow);
    case (follow)
      1: return 8'($urandom_range(8'hC0, 8'hDF));
      2: return 8'($urandom_range(8'hE0, 8'hEF));
      default: return 8'($urandom_range(8'hF0, 8'hF7));
    endcase
  endfunction

  // Following bytes are mostly proper continuation bytes. Now and then any
  // nonzero value is used, since the block only masks their low six bits.
  function automatic logic [7:0] trail_byte();
    if ($urandom_range(7) == 0) return 8'($urandom_range(8'h01, 8'hFF));
    return 8'($urandom_range(8'h80, 8'hBF));
  endfunction

  // One string of up to six characters, closed by a zero byte. Most characters
  // are well formed with random content. The rest are invalid leads, or a
  // sequence cut short by the zero byte, which also ends the string.
  task automatic send_string();
    int chars;
    int pick;
    int follow;
    chars = $urandom_range(0, 6);
    for (int c = 0; c < chars; c++) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_byte(8'($urandom_range(8'h01, 8'h7F)));
      end else if (pick < 80) begin
        follow = (pick < 50) ? 1 : (pick < 65) ? 2 : 3;
        send_byte(lead_byte(follow));
        repeat (follow) send_byte(trail_byte());
      end else if (pick < 88) begin
        send_byte($urandom_range(1) ? 8'($urandom_range(8'h80, 8'hBF))
                                    : 8'($urandom_range(8'hF8, 8'hFF)));
      end else begin
        // The held bytes may themselves be leads, so that the block has to
        // decode them again once the zero byte arrives.
        follow = $urandom_range(1, 3);
        send_byte(lead_byte(follow));
        repeat ($urandom_range(0, follow - 1))
          send_byte($urandom_range(1) ? trail_byte() : 8'($urandom_range(8'h01, 8'hFF)));
        send_byte(8'h00);
        return;
      end
    end
    send_byte(8'h00);
  endtask

  // The receiver decides pop once per cycle outside a hold-off. A hold-off
  // request from the stimulus keeps pop low through the LongHold stretch, counted
  // here, while the sender offers bytes until the block fills up and raises full.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        pop <= 1'b0;
        repeat (LongHold - 1) @(posedge clk);
      end else begin
        pop <= ($urandom_range(99) >= take_idle_pct);
      end
    end
  end

  // Ends the run when no transfer has happened on either side for too long.
  initial begin : watchdog
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QuietLimit) begin
      @(posedge clk);
      if (!rst_n || (push && !full) || (pop && !empty)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // First phase: the sender idles now and then, the receiver most of the time.
    send_idle_pct = 21;
    take_idle_pct = 65;

    // Directed strings. A zero byte with nothing held is a lone terminator.
    send_byte(8'h00);
    // The top bits of a following byte are not checked: C3 41 gives 00C1.
    send_byte(8'hC3);
    send_byte(8'h41);
    // An overlong zero passes through as a plain 0000 unit, not a terminator.
    send_byte(8'hC0);
    send_byte(8'h80);
    // A three-byte character.
    send_byte(8'hE2);
    send_byte(8'h82);
    send_byte(8'hAC);
    // The largest four-byte value, which becomes a surrogate pair.
    send_byte(8'hF7);
    send_byte(8'hBF);
    send_byte(8'hBF);
    send_byte(8'hBF);
    // Invalid leads from both ranges, each giving a replacement unit.
    send_byte(8'h80);
    send_byte(8'hF8);
    send_byte(8'hFF);
    // Cut short with three bytes held: three replacement units and the
    // terminator, the most units one byte can release.
    send_byte(8'hF4);
    send_byte(8'hF0);
    send_byte(8'h9F);
    send_byte(8'h00);
    // Cut short with a plain character held behind the lead.
    send_byte(8'hE2);
    send_byte(8'h41);
    send_byte(8'h00);
    // Cut short with a complete two-byte character held behind the lead.
    send_byte(8'hF0);
    send_byte(8'hC3);
    send_byte(8'hA9);
    send_byte(8'h00);

    while (bytes_sent < 26 + PhaseBytes) send_string();

    // Second phase: the sender mostly idles and the receiver rarely does.
    send_idle_pct = 65;
    take_idle_pct = 21;
    while (bytes_sent < 26 + 2 * PhaseBytes) send_string();

    // Third phase: neither side idles, apart from one long receiver hold-off
    // at its start, during which the block has to stall its input.
    send_idle_pct = 0;
    take_idle_pct = 0;
    hold_off_req = 1'b1;
    while (bytes_sent < 26 + 3 * PhaseBytes) send_string();

    push <= 1'b0;
    // The checker publishes its count as a registered output.
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[files.f]
sv/u2u_pkg.sv
sv/u2u_front.sv
sv/u2u_queue.sv
sv/u2u_back.sv
sv/utf8_to_utf16_transcoder_unit.sv
tb/sv/utf8_to_utf16_transcoder_checker.sv
tb/sv/utf8_to_utf16_transcoder_unit_test.sv
